// ===== rtl/box_sum_3x3_windows_defines.svh =====
// ----------------------------------------------------------------------------
// Box sum 3x3 assertion macros
// Shared assertion shorthands for the box sum block. Each macro expects
// clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef BOX_SUM_3X3_WINDOWS_DEFINES_SVH
`define BOX_SUM_3X3_WINDOWS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bsw_pkg.sv =====
// ----------------------------------------------------------------------------
// Box sum 3x3 package
// Widths, register indexes, the hand-off struct and size clamping shared by
// the box sum modules.
// ----------------------------------------------------------------------------
package bsw_pkg;

  // Frame geometry and element width.
  localparam int MaxCols     = 64;
  localparam int MaxRows     = 64;
  localparam int ElemBits    = 16;
  localparam int Win         = 3;
  localparam int ColBits     = $clog2(MaxCols);
  localparam int RowBits     = $clog2(MaxRows);
  localparam int SizeBits    = 7;
  localparam int ColSumBits  = ElemBits + 2;
  localparam int WinSumBits  = ElemBits + 4;
  localparam int SumBits     = 32;
  localparam int LineBits    = 2 * ElemBits;
  localparam int CfgIdxBits  = 1;
  localparam int CfgDataBits = SizeBits;

  // Reset sizes of the frame.
  localparam logic [SizeBits-1:0] SizeReset = SizeBits'(5);

  // Configuration register indexes.
  typedef enum logic [CfgIdxBits-1:0] {
    RegRows = 1'b0,
    RegCols = 1'b1
  } bsw_reg_e;

  // One accepted element's outcome, passed to the result stage.
  typedef struct packed {
    logic                         win;
    logic                         last;
    logic signed [WinSumBits-1:0] sum;
    logic        [RowBits-1:0]    top;
    logic        [ColBits-1:0]    left;
  } bsw_item_t;

  // Saturate a size register into Win..hi.
  function automatic logic [SizeBits-1:0] clamp_size(input logic [SizeBits-1:0] v,
                                                     input logic [SizeBits-1:0] hi);
    logic [SizeBits-1:0] res;
    res = v;
    if (v < SizeBits'(Win)) begin
      res = SizeBits'(Win);
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

endpackage

// ===== rtl/bsw_if.sv =====
// ----------------------------------------------------------------------------
// Box sum 3x3 channel interfaces
// Valid/ready channels for input elements and for result items.
// ----------------------------------------------------------------------------

// Element channel.
interface bsw_in_if import bsw_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [ElemBits-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

// Result channel.
interface bsw_out_if import bsw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SumBits-1:0] sum_value;
  logic        [RowBits-1:0] window_top_row;
  logic        [ColBits-1:0] window_left_col;
  logic                      is_total;
  logic                      last_of_frame;

  modport source (output valid, output sum_value, output window_top_row,
                  output window_left_col, output is_total, output last_of_frame,
                  input ready);
  modport sink   (input valid, input sum_value, input window_top_row,
                  input window_left_col, input is_total, input last_of_frame,
                  output ready);
endinterface

// ===== rtl/box_sum_3x3_windows.sv =====
// A result item passes through the item register, then the result register.
// Throughput: one element per cycle while the result side takes items; the last
// element of a frame gives two result items (its window sum, then the frame total)
// and holds off the next element until its window sum has left. Line store reads
// are registered ahead, by the next column.
// Reset (async, active low) clears positions, column cells, total and sets both
// sizes to 5; line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Box sum 3x3 windows
// Streaming 3x3 window sums over a raster-order matrix with a per-frame total.
// ----------------------------------------------------------------------------
module box_sum_3x3_windows import bsw_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  bsw_in_if.sink                 elem_i,
  bsw_out_if.source              res_o
);

  logic [SizeBits-1:0]          rows_q, cols_q;
  logic [SizeBits-1:0]          rows_eff, cols_eff;
  logic [RowBits-1:0]           row_d, row_q;
  logic [ColBits-1:0]           col_d, col_q;
  logic                         accept;
  logic                         item_ready;
  logic                         last_col, last_row, last_elem;
  logic [LineBits-1:0]          line_rd;
  logic [LineBits-1:0]          line_wr;
  logic signed [ElemBits-1:0]   upper, lower;
  logic signed [ColSumBits-1:0] colsum;
  logic signed [ColSumBits-1:0] cell_data [Win];
  logic signed [WinSumBits-1:0] win_sum;
  bsw_item_t                    item;

  // Size registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= SizeReset;
      cols_q <= SizeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRows: rows_q <= cfg_data_i;
        RegCols: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rows_eff = clamp_size(rows_q, SizeBits'(MaxRows));
  assign cols_eff = clamp_size(cols_q, SizeBits'(MaxCols));

  assign accept       = elem_i.valid && item_ready;
  assign elem_i.ready = item_ready;

  // Raster position.
  assign last_col  = SizeBits'(col_q) >= (cols_eff - SizeBits'(1));
  assign last_row  = SizeBits'(row_q) >= (rows_eff - SizeBits'(1));
  assign last_elem = last_col && last_row;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (accept) begin
      if (last_elem) begin
        row_d = '0;
        col_d = '0;
      end else if (last_col) begin
        row_d = row_q + RowBits'(1);
        col_d = '0;
      end else begin
        col_d = col_q + ColBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Line stores: read the next column ahead, rotate rows on accept.
  assign upper   = line_rd[LineBits-1:ElemBits];
  assign lower   = line_rd[ElemBits-1:0];
  assign line_wr = {lower, elem_i.element_value};

  bsw_line_store u_line_store (
    .clk_i     (clk_i),
    .wr_en_i   (accept),
    .wr_addr_i (col_q),
    .wr_data_i (line_wr),
    .rd_addr_i (col_d),
    .rd_data_o (line_rd)
  );

  // Vertical sum of the current column.
  assign colsum = ColSumBits'(upper) + ColSumBits'(lower) + ColSumBits'(elem_i.element_value);

  // Chain of column cells, oldest at index 0, newest fed from the column sum.
  for (genvar k = 0; k < Win; k++) begin : g_cells
    logic signed [ColSumBits-1:0] cell_in;
    if (k == Win - 1) begin : g_head
      assign cell_in = colsum;
    end else begin : g_link
      assign cell_in = cell_data[k+1];
    end
    bsw_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .clear_i (accept && last_elem),
      .data_i  (cell_in),
      .data_o  (cell_data[k])
    );
  end

  // Window sum over the two newer cells and the incoming column.
  assign win_sum = WinSumBits'(cell_data[1]) + WinSumBits'(cell_data[2]) +
                   WinSumBits'(colsum);

  always_comb begin
    item.win  = (row_q >= RowBits'(2)) && (col_q >= ColBits'(2));
    item.last = last_elem;
    item.sum  = win_sum;
    item.top  = row_q - RowBits'(2);
    item.left = col_q - ColBits'(2);
  end

  // Result stage.
  bsw_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (elem_i.valid),
    .item_i         (item),
    .item_ready_o   (item_ready),
    .out_valid_o    (res_o.valid),
    .out_ready_i    (res_o.ready),
    .out_sum_o      (res_o.sum_value),
    .out_top_o      (res_o.window_top_row),
    .out_left_o     (res_o.window_left_col),
    .out_is_total_o (res_o.is_total),
    .out_last_o     (res_o.last_of_frame)
  );

endmodule

// ===== rtl/bsw_cell.sv =====
// ----------------------------------------------------------------------------
// Box sum column cell
// One link of the column-sum chain: holds one vertical 3-element sum and
// passes it to its older neighbor when an element is accepted.
// ----------------------------------------------------------------------------
module bsw_cell import bsw_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         shift_i,
  input  logic                         clear_i,
  input  logic signed [ColSumBits-1:0] data_i,
  output logic signed [ColSumBits-1:0] data_o
);

  logic signed [ColSumBits-1:0] data_d, data_q;

  // Clear at frame end, otherwise take the newer neighbor's sum on a shift.
  always_comb begin
    data_d = data_q;
    if (clear_i) begin
      data_d = '0;
    end else if (shift_i) begin
      data_d = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

// ===== rtl/bsw_line_store.sv =====
// ----------------------------------------------------------------------------
// Box sum line store
// Holds the two previous rows, one word per column (upper row in the high
// half). One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bsw_line_store import bsw_pkg::*; (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [ColBits-1:0]  wr_addr_i,
  input  logic [LineBits-1:0] wr_data_i,
  input  logic [ColBits-1:0]  rd_addr_i,
  output logic [LineBits-1:0] rd_data_o
);

  logic [LineBits-1:0] mem_q [MaxCols];
  logic [LineBits-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/bsw_emit.sv =====
// ----------------------------------------------------------------------------
// Box sum result stage
// Holds one accepted element's outcome, turns it into up to two result
// items, keeps the running total and drives the result register.
// ----------------------------------------------------------------------------
`include "box_sum_3x3_windows_defines.svh"

module bsw_emit import bsw_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      item_valid_i,
  input  bsw_item_t                 item_i,
  output logic                      item_ready_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SumBits-1:0] out_sum_o,
  output logic        [RowBits-1:0] out_top_o,
  output logic        [ColBits-1:0] out_left_o,
  output logic                      out_is_total_o,
  output logic                      out_last_o
);

  bsw_item_t             item_d, item_q;
  logic                  win_pend_d, win_pend_q;
  logic                  tot_pend_d, tot_pend_q;
  logic [SumBits-1:0]    total_d, total_q;
  logic                  out_valid_d, out_valid_q;
  logic [SumBits-1:0]    out_sum_d, out_sum_q;
  logic [RowBits-1:0]    out_top_d, out_top_q;
  logic [ColBits-1:0]    out_left_d, out_left_q;
  logic                  out_is_total_d, out_is_total_q;
  logic                  load;
  logic                  busy;
  logic                  finishing;
  logic [SumBits-1:0]    win_sum_ext;

  // The result register can take a new item when empty or being drained.
  assign load        = !out_valid_q || out_ready_i;
  assign busy        = win_pend_q || tot_pend_q;
  assign finishing   = load && (win_pend_q != tot_pend_q);
  assign item_ready_o = !busy || finishing;
  assign win_sum_ext = {{(SumBits - WinSumBits){item_q.sum[WinSumBits-1]}}, item_q.sum};

  // Window result first, then the frame total; a new element lands when nothing
  // is pending or as the last pending result leaves.
  always_comb begin
    item_d         = item_q;
    win_pend_d     = win_pend_q;
    tot_pend_d     = tot_pend_q;
    total_d        = total_q;
    out_valid_d    = out_valid_q;
    out_sum_d      = out_sum_q;
    out_top_d      = out_top_q;
    out_left_d     = out_left_q;
    out_is_total_d = out_is_total_q;

    if (load) begin
      out_valid_d = busy;
      if (win_pend_q) begin
        out_sum_d      = win_sum_ext;
        out_top_d      = item_q.top;
        out_left_d     = item_q.left;
        out_is_total_d = 1'b0;
        total_d        = total_q + win_sum_ext;
        win_pend_d     = 1'b0;
      end else if (tot_pend_q) begin
        out_sum_d      = total_q;
        out_top_d      = '0;
        out_left_d     = '0;
        out_is_total_d = 1'b1;
        total_d        = '0;
        tot_pend_d     = 1'b0;
      end
    end

    if (item_valid_i && item_ready_o) begin
      item_d     = item_i;
      win_pend_d = item_i.win;
      tot_pend_d = item_i.last;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_pend_q  <= 1'b0;
      tot_pend_q  <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      win_pend_q  <= win_pend_d;
      tot_pend_q  <= tot_pend_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    item_q         <= item_d;
    out_sum_q      <= out_sum_d;
    out_top_q      <= out_top_d;
    out_left_q     <= out_left_d;
    out_is_total_q <= out_is_total_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_sum_o      = out_sum_q;
  assign out_top_o      = out_top_q;
  assign out_left_o     = out_left_q;
  assign out_is_total_o = out_is_total_q;
  assign out_last_o     = out_is_total_q;

  // An element is never taken while both of the previous one's results wait.
  `BSW_ASSERT_NOW(a_no_accept_two_pend, win_pend_q && tot_pend_q, !item_ready_o, "accept with two results pending")
  // Issuing the total clears the running sum and marks the result as total.
  `BSW_ASSERT_NEXT(a_total_clears, load && !win_pend_q && tot_pend_q, (total_q == '0) && out_valid_q && out_is_total_q, "total issue did not clear")
  // A total result carries no window position.
  `BSW_ASSERT_NOW(a_total_no_pos, out_valid_q && out_is_total_q, (out_top_q == '0) && (out_left_q == '0), "total with position")

endmodule

// ===== dv/box_sum_3x3_windows_tb.sv =====
// ----------------------------------------------------------------------------
// Box sum 3x3 windows testbench
// Streams matrix frames into the block and checks every window sum and every
// frame total against a cycle-free prediction of the block. Covers the reset
// size, saturated and extreme sizes, resizing in the middle of a frame, long
// output stalls and random frames under several idle patterns.
// ----------------------------------------------------------------------------
module box_sum_3x3_windows_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bsw_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 8;
  localparam logic signed [ElemBits-1:0] ElemMax = {1'b0, {(ElemBits-1){1'b1}}};
  localparam logic signed [ElemBits-1:0] ElemMin = {1'b1, {(ElemBits-1){1'b0}}};

  // How the elements of a frame are chosen.
  typedef enum int {FillRandom, FillMax, FillMin} fill_e;

  // One result item as the block should give it.
  typedef struct packed {
    logic signed [SumBits-1:0] sum;
    logic        [RowBits-1:0] top;
    logic        [ColBits-1:0] left;
    logic                      is_total;
    logic                      last;
  } box_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  bsw_in_if  elem_if ();
  bsw_out_if res_if ();

  box_sum_3x3_windows u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .elem_i     (elem_if),
    .res_o      (res_if)
  );

  // Predicted state of the block.
  logic [SizeBits-1:0]        rows_reg = SizeReset;
  logic [SizeBits-1:0]        cols_reg = SizeReset;
  logic signed [ElemBits-1:0] upper_line [MaxCols] = '{default: '0};
  logic signed [ElemBits-1:0] lower_line [MaxCols] = '{default: '0};
  int                         col_sums [Win] = '{default: 0};
  int                         cur_row = 0;
  int                         cur_col = 0;
  logic [SumBits-1:0]         frame_total = '0;

  box_result_t pending_results [$];
  int          error_count = 0;
  int          items_sent = 0;
  int          send_idle_pct = 18;
  int          recv_idle_pct = 55;
  int          stall_left = 0;
  int          cycle_count = 0;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: a run that takes too long has failed.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Saturate a raw size register into its legal range.
  function automatic int sat_size(input logic [SizeBits-1:0] raw, input int hi);
    if (raw < Win) return Win;
    if (raw > hi) return hi;
    return int'(raw);
  endfunction

  // Advance the predicted state by one element and queue its results.
  function automatic void predict_window_sums(input logic signed [ElemBits-1:0] x);
    int          rows;
    int          cols;
    int          idx;
    int          colsum;
    int          wsum;
    bit          at_last_col;
    bit          at_last_row;
    box_result_t res;
    rows = sat_size(rows_reg, MaxRows);
    cols = sat_size(cols_reg, MaxCols);
    idx = (cur_col < MaxCols) ? cur_col : MaxCols - 1;
    colsum = int'(upper_line[idx]) + int'(lower_line[idx]) + int'(x);
    at_last_col = (cur_col >= cols - 1);
    at_last_row = (cur_row >= rows - 1);

    col_sums[0] = col_sums[1];
    col_sums[1] = col_sums[2];
    col_sums[2] = colsum;
    upper_line[idx] = lower_line[idx];
    lower_line[idx] = x;

    // A full window ends at this element.
    if (cur_row >= 2 && cur_col >= 2) begin
      wsum = col_sums[0] + col_sums[1] + col_sums[2];
      frame_total = frame_total + SumBits'(wsum);
      res.sum = SumBits'(wsum);
      res.top = RowBits'(cur_row - 2);
      res.left = ColBits'(cur_col - 2);
      res.is_total = 1'b0;
      res.last = 1'b0;
      pending_results.push_back(res);
    end

    // Frame end gives the total and clears the frame state.
    if (at_last_col && at_last_row) begin
      res.sum = frame_total;
      res.top = '0;
      res.left = '0;
      res.is_total = 1'b1;
      res.last = 1'b1;
      pending_results.push_back(res);
      cur_row = 0;
      cur_col = 0;
      frame_total = '0;
      col_sums = '{default: 0};
    end else if (at_last_col) begin
      cur_col = 0;
      cur_row = cur_row + 1;
    end else begin
      cur_col = cur_col + 1;
    end
  endfunction

  // Pick one element value, with the extremes weighted up.
  function automatic logic signed [ElemBits-1:0] rand_element(input fill_e fill);
    int pick;
    if (fill == FillMax) return ElemMax;
    if (fill == FillMin) return ElemMin;
    pick = $urandom_range(0, 15);
    if (pick < 2) return ElemMax;
    if (pick < 4) return ElemMin;
    if (pick == 4) return '0;
    if (pick == 5) return '1;
    return ElemBits'($urandom);
  endfunction

  // Offer one item after a random gap and wait until it is accepted.
  task automatic send_element(input logic signed [ElemBits-1:0] value);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      elem_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    elem_if.valid <= 1'b1;
    elem_if.element_value <= value;
    do @(posedge clk_i); while (!elem_if.ready);
    predict_window_sums(value);
    items_sent++;
  endtask

  task automatic send_random_elements(input int count);
    repeat (count) send_element(rand_element(FillRandom));
  endtask

  // Send elements until the predicted position wraps to the frame start.
  task automatic finish_frame(input fill_e fill);
    do send_element(rand_element(fill)); while (cur_row != 0 || cur_col != 0);
  endtask

  // Stop offering items and wait until every result has arrived and the
  // block has had time to settle.
  task automatic wait_results_drained();
    elem_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the row size register, then the column size register, on consecutive edges.
  task automatic set_frame_size(input logic [SizeBits-1:0] rows_raw,
                                input logic [SizeBits-1:0] cols_raw);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= RegRows;
    cfg_data_i <= rows_raw;
    @(posedge clk_i);
    rows_reg = rows_raw;
    cfg_idx_i <= RegCols;
    cfg_data_i <= cols_raw;
    @(posedge clk_i);
    cols_reg = cols_raw;
    cfg_we_i <= 1'b0;
  endtask

  task automatic check_field(input string what, input logic signed [SumBits-1:0] want,
                             input logic signed [SumBits-1:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Result side: check each accepted item, then pick the next ready value.
  initial begin : result_checker
    box_result_t want;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result item, expected none, actual sum %0d",
                   $time, res_if.sum_value);
        end else begin
          want = pending_results.pop_front();
          check_field("sum_value", want.sum, res_if.sum_value);
          check_field("window_top_row", SumBits'(want.top),
                      SumBits'(res_if.window_top_row));
          check_field("window_left_col", SumBits'(want.left),
                      SumBits'(res_if.window_left_col));
          check_field("is_total", SumBits'(want.is_total), SumBits'(res_if.is_total));
          check_field("last_of_frame", SumBits'(want.last),
                      SumBits'(res_if.last_of_frame));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // A 5x5 frame at the reset size with extreme and corner values.
  task automatic test_reset_size_frame();
    logic signed [ElemBits-1:0] vals [25] = '{
      ElemMax, ElemMax, ElemMax, ElemMin, ElemMin,
      ElemMax, ElemMax, ElemMax, ElemMin, ElemMin,
      ElemMax, ElemMax, ElemMax, ElemMin, ElemMin,
      16'sd0, -16'sd1, 16'sd1, ElemMin, ElemMax,
      16'sh5555, 16'shAAAA, 16'sd0, -16'sd1, ElemMax};
    foreach (vals[i]) send_element(vals[i]);
  endtask

  // Smallest and largest sizes, including raw values that saturate.
  task automatic test_size_extremes();
    wait_results_drained();
    set_frame_size(7'd3, 7'd3);
    finish_frame(FillMax);
    finish_frame(FillMin);
    wait_results_drained();
    set_frame_size(7'd64, 7'd0);
    finish_frame(FillRandom);
    wait_results_drained();
    set_frame_size(7'd1, 7'd127);
    finish_frame(FillRandom);
    wait_results_drained();
    set_frame_size(7'd2, 7'd1);
    finish_frame(FillRandom);
    wait_results_drained();
    set_frame_size(7'd7, 7'd6);
    finish_frame(FillRandom);
  endtask

  // Size changes while a frame is open; columns never grow.
  task automatic test_resize_mid_frame();
    // Shrink both while inside the third row.
    wait_results_drained();
    set_frame_size(7'd6, 7'd8);
    send_random_elements(19);
    wait_results_drained();
    set_frame_size(7'd4, 7'd5);
    finish_frame(FillRandom);
    // Position already past the new last row and column ends the frame.
    wait_results_drained();
    set_frame_size(7'd5, 7'd8);
    send_random_elements(30);
    wait_results_drained();
    set_frame_size(7'd3, 7'd4);
    finish_frame(FillRandom);
    // More rows than the frame started with.
    wait_results_drained();
    set_frame_size(7'd3, 7'd5);
    send_random_elements(8);
    wait_results_drained();
    set_frame_size(7'd6, 7'd5);
    finish_frame(FillRandom);
  endtask

  // Long output stall while items keep coming, then a pause until empty.
  task automatic test_stall_backpressure();
    wait_results_drained();
    set_frame_size(7'd5, 7'd6);
    stall_left = 150;
    finish_frame(FillRandom);
    finish_frame(FillRandom);
    wait_results_drained();
    finish_frame(FillRandom);
  endtask

  // Random frames, some resized midway, under three idle patterns.
  task automatic test_random_frames();
    int                  phase_goal;
    int                  frame_len;
    int                  cols_eff;
    int                  pick;
    logic [SizeBits-1:0] rows_raw;
    logic [SizeBits-1:0] cols_raw;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 55;
        end
        1: begin
          send_idle_pct = 55;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_goal = items_sent + 10;
      while (items_sent < phase_goal) begin
        wait_results_drained();
        // Mostly small frames; now and then a tall or a wide one.
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          rows_raw = SizeBits'($urandom_range(10, 24));
          cols_raw = SizeBits'($urandom_range(0, 4));
        end else if (pick == 1) begin
          rows_raw = SizeBits'($urandom_range(0, 4));
          cols_raw = SizeBits'($urandom_range(10, 24));
        end else begin
          rows_raw = SizeBits'($urandom_range(0, 9));
          cols_raw = SizeBits'($urandom_range(0, 9));
        end
        set_frame_size(rows_raw, cols_raw);
        // Sometimes resize partway through the frame.
        if ($urandom_range(0, 5) == 0) begin
          cols_eff = sat_size(cols_raw, MaxCols);
          frame_len = sat_size(rows_raw, MaxRows) * cols_eff;
          send_random_elements($urandom_range(1, frame_len - 1));
          wait_results_drained();
          set_frame_size(SizeBits'($urandom_range(0, 8)),
                         SizeBits'($urandom_range(0, cols_eff)));
        end
        finish_frame(FillRandom);
      end
    end
  endtask

  // Test sequence.
  initial begin : run_tests
    elem_if.valid = 1'b0;
    elem_if.element_value = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegRows;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_size_frame();
    test_size_extremes();
    test_resize_mid_frame();
    test_stall_backpressure();
    test_random_frames();

    wait_results_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== box_sum_3x3_windows.f =====
+incdir+rtl
rtl/bsw_pkg.sv
rtl/bsw_if.sv
rtl/bsw_cell.sv
rtl/bsw_line_store.sv
rtl/bsw_emit.sv
rtl/box_sum_3x3_windows.sv
dv/box_sum_3x3_windows_tb.sv
